[rtl/core/tpq_pkg.sv]
// Shared constants, command and status codes, and control structs for the two-class FIFO.
package tpq_pkg;

    // Queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // Fixed field widths on the stream ports
    localparam int CMD_W       = 2;
    localparam int ID_W        = 16;
    localparam int STATUS_W    = 2;
    localparam int COUNT_W     = 5;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;

    // Command codes; code 3 is unused and ignored
    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH    = 2'd0,
        CMD_POP_ANY = 2'd1,
        CMD_POP_ORD = 2'd2
    } cmd_t;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-queue command from the decoder
    typedef struct packed {
        logic push;
        logic pop;
    } tpq_ctrl_t;

    // Per-queue status back to the decoder
    typedef struct packed {
        logic empty;
        logic full;
    } tpq_flags_t;

endpackage

[rtl/core/tpq_cell.sv]
// One storage cell of the shifting queue chain.
module tpq_cell
    import tpq_pkg::*;
(
    input  logic               aclk,
    input  logic               shift_en,   // take the neighbor's word (pop)
    input  logic               load_en,    // take the pushed word
    input  logic [ID_BITS-1:0] load_data,
    input  logic [ID_BITS-1:0] next_data,  // word held by the cell behind
    output logic [ID_BITS-1:0] data
);

    logic [ID_BITS-1:0] data_reg;
    logic [ID_BITS-1:0] data_next;

    // Pop shifts toward the head; push loads the first free cell
    always_comb begin
        data_next = data_reg;
        if (shift_en) begin
            data_next = next_data;
        end else if (load_en) begin
            data_next = load_data;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/tpq_queue.sv]
// One FIFO built as a chain of cells with the head in cell 0 and a fill counter.
module tpq_queue
    import tpq_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  tpq_ctrl_t          ctrl,
    input  logic [ID_BITS-1:0] push_data,
    output logic [ID_BITS-1:0] head_data,
    output tpq_flags_t         flags,
    output logic [CNT_W-1:0]   fill,
    output logic [CNT_W-1:0]   fill_after
);

    logic [CNT_W-1:0]   fill_reg;
    logic [CNT_W-1:0]   fill_next;
    logic [ID_BITS-1:0] cell_data [QUEUE_DEPTH];

    // Cell chain: cell i hands its word to cell i-1 on a pop
    for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
        logic [ID_BITS-1:0] behind;
        if (i == QUEUE_DEPTH - 1) begin : g_tail
            assign behind = '0;
        end else begin : g_mid
            assign behind = cell_data[i+1];
        end
        tpq_cell u_cell (
            .aclk      (aclk),
            .shift_en  (ctrl.pop),
            .load_en   (ctrl.push && (fill_reg == CNT_W'(i))),
            .load_data (push_data),
            .next_data (behind),
            .data      (cell_data[i])
        );
    end

    // Fill count; push and pop never come together
    always_comb begin
        fill_next = fill_reg;
        if (ctrl.push) begin
            fill_next = fill_reg + 1'b1;
        end else if (ctrl.pop) begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg <= '0;
        end else begin
            fill_reg <= fill_next;
        end
    end

    assign head_data   = cell_data[0];
    assign flags.empty = (fill_reg == '0);
    assign flags.full  = (fill_reg == CNT_W'(QUEUE_DEPTH));
    assign fill        = fill_reg;
    assign fill_after  = fill_next;

endmodule

[rtl/core/two_class_priority_fifo_unit.sv]
// Top level of the strict-priority two-queue client FIFO.
//
// Two 16-deep FIFOs of client IDs, each a chain of cells with the head in the first cell: a pop
// shifts the whole chain one cell toward the head, a push writes the first free cell. Every
// command word yields one result word, registered in the cycle after acceptance, and a new command
// is taken every cycle while the result register is free or being drained in that same cycle, so
// the sustained rate is one word per clock. Command
// 1 pops the priority queue first and falls back to the ordinary queue; command 2 pops the
// ordinary queue only; a push into a full queue is dropped with status full; code 3 is ignored.
// Both fill counts after the step ride along with every result. Queues are empty after reset.
module two_class_priority_fifo_unit
    import tpq_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // cmd[1:0], client_id[17:2], zero pad
    input  logic [0:0]           s_tuser,  // is_priority[0]
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,  // status[1:0], popped_id[17:2],
                                           // priority_count[22:18], ordinary_count[27:23], pad
    output logic [0:0]           m_tuser   // popped_priority[0]
);

    logic               s_accept;
    cmd_t               cmd;
    logic [ID_W-1:0]    client_id;
    logic               is_priority;

    tpq_ctrl_t          prio_ctrl, ord_ctrl;
    tpq_flags_t         prio_flags, ord_flags;
    logic [ID_BITS-1:0] prio_head, ord_head;
    logic [CNT_W-1:0]   prio_fill, ord_fill;
    logic [CNT_W-1:0]   prio_after, ord_after;

    status_t            status;
    logic [ID_W-1:0]    popped_id;
    logic               popped_priority;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic                 m_tuser_reg, m_tuser_next;

    // Input word fields
    assign s_tready    = !m_tvalid_reg || m_tready;
    assign s_accept    = s_tvalid && s_tready;
    assign cmd         = cmd_t'(s_tdata[CMD_W-1:0]);
    assign client_id   = s_tdata[CMD_W+ID_W-1:CMD_W];
    assign is_priority = s_tuser[0];

    // Command decode against the queue flags
    always_comb begin
        prio_ctrl       = '0;
        ord_ctrl        = '0;
        status          = ST_OK;
        popped_id       = '0;
        popped_priority = 1'b0;
        unique case (cmd)
            CMD_PUSH: begin
                if (is_priority) begin
                    if (prio_flags.full) status = ST_FULL;
                    else                 prio_ctrl.push = s_accept;
                end else begin
                    if (ord_flags.full) status = ST_FULL;
                    else                ord_ctrl.push = s_accept;
                end
            end
            CMD_POP_ANY: begin
                if (!prio_flags.empty) begin
                    prio_ctrl.pop   = s_accept;
                    popped_id       = ID_W'(prio_head);
                    popped_priority = 1'b1;
                end else if (!ord_flags.empty) begin
                    ord_ctrl.pop = s_accept;
                    popped_id    = ID_W'(ord_head);
                end else begin
                    status = ST_EMPTY;
                end
            end
            CMD_POP_ORD: begin
                if (!ord_flags.empty) begin
                    ord_ctrl.pop = s_accept;
                    popped_id    = ID_W'(ord_head);
                end else begin
                    status = ST_EMPTY;
                end
            end
            default: begin
            end
        endcase
    end

    tpq_queue u_prio_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (prio_ctrl),
        .push_data  (ID_BITS'(client_id)),
        .head_data  (prio_head),
        .flags      (prio_flags),
        .fill       (prio_fill),
        .fill_after (prio_after)
    );

    tpq_queue u_ord_q (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ord_ctrl),
        .push_data  (ID_BITS'(client_id)),
        .head_data  (ord_head),
        .flags      (ord_flags),
        .fill       (ord_fill),
        .fill_after (ord_after)
    );

    // Result register
    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        if (s_accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = M_TDATA_W'({COUNT_W'(ord_after), COUNT_W'(prio_after),
                                        popped_id, status});
            m_tuser_next  = popped_priority;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
    end

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Reported counts match the queues right after the step
    a_count_match: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (m_tdata_reg[22:18] == COUNT_W'(prio_fill))
                  && (m_tdata_reg[27:23] == COUNT_W'(ord_fill)))
        else $error("reported counts disagree with queue fill");

    // A fill never exceeds the queue depth
    a_fill_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (prio_fill <= CNT_W'(QUEUE_DEPTH)) && (ord_fill <= CNT_W'(QUEUE_DEPTH)))
        else $error("queue fill beyond depth");

    // A failed result carries no ID and no priority flag
    a_fail_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (status != ST_OK)) |=> (m_tdata_reg[17:2] == '0) && !m_tuser_reg)
        else $error("failed step reports a popped client");

    // A successful priority-first pop only falls back when the priority queue is empty
    a_strict_prio: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && (cmd == CMD_POP_ANY) && !prio_flags.empty) |-> prio_ctrl.pop && !ord_ctrl.pop)
        else $error("priority queue bypassed while not empty");

endmodule
